// ===== hdl/utf8_codepoint_decoder_defines.svh =====
// Assertion macros for the decoder's RTL; only the top-level decoder file includes them.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef UTF8_CODEPOINT_DECODER_DEFINES_SVH
`define UTF8_CODEPOINT_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ucd_pkg.sv =====
`default_nettype none

package ucd_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TERM     = 2'd1,
        ST_OVERLONG = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    // One four-byte window starting at the current string position.
    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
    } window_t;

    // One decoded result.
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_used;
        status_t     status;
    } result_t;

    // A continuation byte has the form 10xxxxxx.
    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ucd_window_if.sv =====
`default_nettype none

// Channel carrying one byte window per transaction.
interface ucd_window_if;
    logic       valid;
    logic       ready;
    logic [7:0] lead_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;

    modport source (
        output valid, lead_byte, second_byte, third_byte, fourth_byte,
        input  ready
    );
    modport sink (
        input  valid, lead_byte, second_byte, third_byte, fourth_byte,
        output ready
    );
endinterface

// Channel carrying one decoded result per transaction.
interface ucd_result_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  bytes_used;
    logic [1:0]  status;

    modport source (
        output valid, code_point, bytes_used, status,
        input  ready
    );
    modport sink (
        input  valid, code_point, bytes_used, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/ucd_decode.sv =====
`default_nettype none

// Combinational decode of one byte window into a code point, advance and status.
module ucd_decode (
    input  ucd_pkg::window_t win,
    output ucd_pkg::result_t res
);

    logic [10:0] v2;
    logic [15:0] v3;
    logic [20:0] v4;

    // Candidate values for the 2-, 3- and 4-byte forms.
    assign v2 = {win.lead_byte[4:0], win.second_byte[5:0]};
    assign v3 = {win.lead_byte[3:0], win.second_byte[5:0], win.third_byte[5:0]};
    assign v4 = {win.lead_byte[2:0], win.second_byte[5:0], win.third_byte[5:0],
                 win.fourth_byte[5:0]};

    // Checks in priority order; the first one that matches decides the result.
    always_comb
    begin
        res.code_point = 21'd0;
        res.bytes_used = 3'd1;
        res.status     = ucd_pkg::ST_INVALID;
        if (!win.lead_byte[7])
        begin
            res.code_point = {13'd0, win.lead_byte};
            res.status     = ucd_pkg::ST_OK;
        end
        else if (win.second_byte == 8'd0)
        begin
            res.bytes_used = 3'd2;
            res.status     = ucd_pkg::ST_TERM;
        end
        else if (win.lead_byte[7:5] == 3'b110 && ucd_pkg::is_cont(win.second_byte))
        begin
            res.bytes_used = 3'd2;
            if (v2[10:7] == 4'd0)
            begin
                res.status = ucd_pkg::ST_OVERLONG;
            end
            else
            begin
                res.code_point = {10'd0, v2};
                res.status     = ucd_pkg::ST_OK;
            end
        end
        else if (win.third_byte == 8'd0)
        begin
            res.bytes_used = 3'd3;
            res.status     = ucd_pkg::ST_TERM;
        end
        else if (win.lead_byte[7:4] == 4'b1110 && ucd_pkg::is_cont(win.second_byte)
                 && ucd_pkg::is_cont(win.third_byte))
        begin
            res.bytes_used = 3'd3;
            if (v3[15:11] == 5'd0)
            begin
                res.status = ucd_pkg::ST_OVERLONG;
            end
            else
            begin
                res.code_point = {5'd0, v3};
                res.status     = ucd_pkg::ST_OK;
            end
        end
        else if (win.fourth_byte == 8'd0)
        begin
            res.bytes_used = 3'd4;
            res.status     = ucd_pkg::ST_TERM;
        end
        else if (win.lead_byte[7:3] == 5'b11110 && ucd_pkg::is_cont(win.second_byte)
                 && ucd_pkg::is_cont(win.third_byte) && ucd_pkg::is_cont(win.fourth_byte))
        begin
            res.bytes_used = 3'd4;
            if (v4[20:16] == 5'd0)
            begin
                res.status = ucd_pkg::ST_OVERLONG;
            end
            else
            begin
                res.code_point = v4;
                res.status     = ucd_pkg::ST_OK;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/utf8_codepoint_decoder.sv =====
// Channel   Direction  Payload
// window    in         lead_byte, second_byte, third_byte, fourth_byte (8 bits each)
// result    out        code_point (21), bytes_used (3), status (2)
//
// One window is taken in every cycle while result is not stalled; a window passes
// through the input register, the decode logic and the result register in turn.
// Reset (rst_n, asynchronous, active low) empties both registers; their data is not reset.
// A stall on result holds the result register, and the input register keeps
// accepting until it too is full.
`default_nettype none
`include "utf8_codepoint_decoder_defines.svh"

module utf8_codepoint_decoder (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ucd_window_if.sink     window,
    ucd_result_if.source   result
);

    logic              in_valid_reg;
    ucd_pkg::window_t  in_data_reg;
    logic              out_valid_reg;
    ucd_pkg::result_t  out_data_reg;
    ucd_pkg::result_t  decoded;
    logic              out_ready;
    logic              in_ready;

    // Each stage takes a new transaction when empty or when its content moves on.
    assign out_ready    = !out_valid_reg || result.ready;
    assign in_ready     = !in_valid_reg || out_ready;
    assign window.ready = in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= window.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && window.valid)
        begin
            in_data_reg <= '{lead_byte:   window.lead_byte,
                             second_byte: window.second_byte,
                             third_byte:  window.third_byte,
                             fourth_byte: window.fourth_byte};
        end
    end

    // Decode logic between the two registers.
    ucd_decode u_decode (
        .win (in_data_reg),
        .res (decoded)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && in_valid_reg)
        begin
            out_data_reg <= decoded;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.code_point = out_data_reg.code_point;
    assign result.bytes_used = out_data_reg.bytes_used;
    assign result.status     = out_data_reg.status;

    // An accepted window always lands in the input register.
    `UCD_ASSERT_NEXT(a_in_capture, window.valid && window.ready, in_valid_reg,
        "accepted window not held in input register")

    // A decoded window moves into the result register unchanged.
    `UCD_ASSERT_NEXT(a_out_capture, in_valid_reg && out_ready,
        out_valid_reg && out_data_reg == $past(decoded),
        "decoded result not captured")

    // Error results carry a zero code point.
    `UCD_ASSERT_NOW(a_err_zero, out_valid_reg && out_data_reg.status != ucd_pkg::ST_OK,
        out_data_reg.code_point == 21'd0, "error result with nonzero code point")

    // An invalid byte advances by one, and every advance lies in 1 to 4.
    `UCD_ASSERT_NOW(a_advance, out_valid_reg,
        out_data_reg.bytes_used >= 3'd1 && out_data_reg.bytes_used <= 3'd4
        && (out_data_reg.status != ucd_pkg::ST_INVALID || out_data_reg.bytes_used == 3'd1),
        "advance out of range")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    logic clk;
    logic rst_n;

    // Idle and stall percentages for the current phase.
    int source_idle_pct;
    int sink_stall_pct;
    int error_count;

    // Decoded results still waiting to come out of the block, oldest first.
    ucd_pkg::result_t decoded_queue[$];

    ucd_window_if window_ch ();
    ucd_result_if result_ch ();

    utf8_codepoint_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .window (window_ch),
        .result (result_ch)
    );

    // Free-running clock with a 12 ns period.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Predict the result of one window: ASCII first, then each longer form in turn,
    // with a zero byte ending the sequence wherever a continuation is looked for.
    function automatic ucd_pkg::result_t decode_utf8_window(input ucd_pkg::window_t w);
        ucd_pkg::result_t r;
        logic [20:0]      v;
        r.code_point = '0;
        r.bytes_used = 3'd1;
        r.status     = ucd_pkg::ST_INVALID;
        v            = '0;
        if (!w.lead_byte[7])
        begin
            r.code_point = {13'd0, w.lead_byte};
            r.status     = ucd_pkg::ST_OK;
        end
        else if (w.second_byte == 8'h00)
        begin
            r.bytes_used = 3'd2;
            r.status     = ucd_pkg::ST_TERM;
        end
        else if (w.lead_byte[7:5] == 3'b110 && w.second_byte[7:6] == 2'b10)
        begin
            v = {10'd0, w.lead_byte[4:0], w.second_byte[5:0]};
            r.bytes_used = 3'd2;
            r.status     = (v[10:7] == 4'd0) ? ucd_pkg::ST_OVERLONG : ucd_pkg::ST_OK;
            r.code_point = (r.status == ucd_pkg::ST_OK) ? v : '0;
        end
        else if (w.third_byte == 8'h00)
        begin
            r.bytes_used = 3'd3;
            r.status     = ucd_pkg::ST_TERM;
        end
        else if (w.lead_byte[7:4] == 4'b1110 && w.second_byte[7:6] == 2'b10
                 && w.third_byte[7:6] == 2'b10)
        begin
            v = {5'd0, w.lead_byte[3:0], w.second_byte[5:0], w.third_byte[5:0]};
            r.bytes_used = 3'd3;
            r.status     = (v[15:11] == 5'd0) ? ucd_pkg::ST_OVERLONG : ucd_pkg::ST_OK;
            r.code_point = (r.status == ucd_pkg::ST_OK) ? v : '0;
        end
        else if (w.fourth_byte == 8'h00)
        begin
            r.bytes_used = 3'd4;
            r.status     = ucd_pkg::ST_TERM;
        end
        else if (w.lead_byte[7:3] == 5'b11110 && w.second_byte[7:6] == 2'b10
                 && w.third_byte[7:6] == 2'b10 && w.fourth_byte[7:6] == 2'b10)
        begin
            v = {w.lead_byte[2:0], w.second_byte[5:0], w.third_byte[5:0],
                 w.fourth_byte[5:0]};
            r.bytes_used = 3'd4;
            r.status     = (v[20:16] == 5'd0) ? ucd_pkg::ST_OVERLONG : ucd_pkg::ST_OK;
            r.code_point = (r.status == ucd_pkg::ST_OK) ? v : '0;
        end
        return r;
    endfunction

    // Build a random window: mostly well-formed sequences with random payload,
    // some with the lead at its smallest value to hit overlong forms, some with
    // a zero or a damaged continuation byte, and the rest pure noise.
    function automatic ucd_pkg::window_t random_window();
        ucd_pkg::window_t w;
        int               kind;
        int               pos;
        w.lead_byte   = 8'($urandom);
        w.second_byte = 8'($urandom);
        w.third_byte  = 8'($urandom);
        w.fourth_byte = 8'($urandom);
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            w.lead_byte[7] = 1'b0;
        end
        else if (kind < 75)
        begin
            w.second_byte[7:6] = 2'b10;
            w.third_byte[7:6]  = 2'b10;
            w.fourth_byte[7:6] = 2'b10;
            if (kind < 35)
                w.lead_byte[7:5] = 3'b110;
            else if (kind < 55)
                w.lead_byte[7:4] = 4'b1110;
            else
                w.lead_byte[7:3] = 5'b11110;
            // Smallest lead of each length makes overlong values likely.
            if ($urandom_range(5) == 0)
            begin
                if (kind < 35)
                    w.lead_byte[4:1] = 4'd0;
                else if (kind < 55)
                    w.lead_byte[3:0] = 4'd0;
                else
                    w.lead_byte[2:0] = 3'd0;
            end
        end
        pos = $urandom_range(3, 1);
        if ($urandom_range(9) == 0)
        begin
            case (pos)
                1: w.second_byte = 8'h00;
                2: w.third_byte  = 8'h00;
                default: w.fourth_byte = 8'h00;
            endcase
        end
        else if ($urandom_range(9) == 0)
        begin
            case (pos)
                1: w.second_byte[7:6] = 2'($urandom);
                2: w.third_byte[7:6]  = 2'($urandom);
                default: w.fourth_byte[7:6] = 2'($urandom);
            endcase
        end
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Send one window, with a random gap before it, and record its expected result
    // once the transaction has been accepted.
    task automatic send_window(input ucd_pkg::window_t w);
        if ($urandom_range(99) < source_idle_pct)
        begin
            window_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < source_idle_pct);
        end
        window_ch.valid       <= 1'b1;
        window_ch.lead_byte   <= w.lead_byte;
        window_ch.second_byte <= w.second_byte;
        window_ch.third_byte  <= w.third_byte;
        window_ch.fourth_byte <= w.fourth_byte;
        do @(posedge clk); while (!window_ch.ready);
        decoded_queue.push_back(decode_utf8_window(w));
    endtask

    // Stop sending and hold off until every expected result has come out.
    task automatic wait_for_drain();
        window_ch.valid <= 1'b0;
        while (decoded_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_windows(input int count);
        for (int i = 0; i < count; i++)
            send_window(random_window());
    endtask

    // Boundary values of every form and each special case, back to back.
    task automatic test_directed_windows();
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        send_window(32'h00_00_00_00);   // ASCII zero
        send_window(32'h7F_FF_FF_FF);   // largest ASCII
        send_window(32'hC2_80_00_00);   // smallest two-byte value
        send_window(32'hDF_BF_00_00);   // largest two-byte value
        send_window(32'hC0_80_41_41);   // overlong two-byte form
        send_window(32'hC1_BF_41_41);   // overlong two-byte form, top of range
        send_window(32'hC2_00_41_41);   // sequence ended by a zero second byte
        send_window(32'h80_00_00_00);   // zero after a stray continuation lead
        send_window(32'hE0_A0_80_00);   // smallest three-byte value
        send_window(32'hEF_BF_BF_41);   // largest three-byte value
        send_window(32'hE0_80_80_41);   // overlong three-byte form
        send_window(32'hE0_9F_BF_41);   // overlong three-byte form, top of range
        send_window(32'hED_A0_80_41);   // surrogate passes through
        send_window(32'hE2_82_00_41);   // sequence ended by a zero third byte
        send_window(32'hC2_41_00_41);   // bad two-byte form, then a zero third byte
        send_window(32'hF0_90_80_80);   // smallest four-byte value
        send_window(32'hF7_BF_BF_BF);   // largest four-byte value
        send_window(32'hF4_90_80_80);   // above the Unicode range, still decoded
        send_window(32'hF0_8F_BF_BF);   // overlong four-byte form
        send_window(32'hF0_90_80_00);   // sequence ended by a zero fourth byte
        send_window(32'h80_80_80_80);   // lone continuation lead
        send_window(32'hF8_88_80_80);   // five-byte lead is invalid
        send_window(32'hFF_FF_FF_FF);   // all ones
        send_window(32'hC2_C0_41_41);   // bad continuation byte
        send_window(32'hE1_80_41_41);   // three-byte form cut short
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        send_random_windows(235);
    endtask

    // Sparse source, with one full drain in the middle.
    task automatic test_sparse_source();
        source_idle_pct = 75;
        sink_stall_pct  = 0;
        send_random_windows(115);
        wait_for_drain();
        send_random_windows(115);
    endtask

    task automatic test_slow_sink();
        source_idle_pct = 0;
        sink_stall_pct  = 75;
        send_random_windows(235);
    endtask

    task automatic test_mixed_idling();
        source_idle_pct = 24;
        sink_stall_pct  = 24;
        send_random_windows(235);
    endtask

    // Result ready with random stalls.
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin
        ucd_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (decoded_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result cp=%h used=%0d status=%0d",
                    result_ch.code_point, result_ch.bytes_used, result_ch.status));
            end
            else
            begin
                want = decoded_queue.pop_front();
                if (result_ch.code_point !== want.code_point)
                    report_mismatch($sformatf("code_point %h, expected %h",
                        result_ch.code_point, want.code_point));
                if (result_ch.bytes_used !== want.bytes_used)
                    report_mismatch($sformatf("bytes_used %0d, expected %0d",
                        result_ch.bytes_used, want.bytes_used));
                if (result_ch.status !== 2'(want.status))
                    report_mismatch($sformatf("status %0d, expected %s",
                        result_ch.status, want.status.name()));
            end
        end
    end

    // Main sequence.
    initial
    begin
        error_count     = 0;
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        rst_n                 <= 1'b0;
        window_ch.valid       <= 1'b0;
        window_ch.lead_byte   <= 8'h00;
        window_ch.second_byte <= 8'h00;
        window_ch.third_byte  <= 8'h00;
        window_ch.fourth_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_windows();
        test_back_to_back();
        test_sparse_source();
        test_slow_sink();
        test_mixed_idling();

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ucd_pkg.sv
hdl/ucd_window_if.sv
hdl/ucd_decode.sv
hdl/utf8_codepoint_decoder.sv
test/tb.sv
